### design/amfl_pkg.sv
// Shared types, widths, constants and coefficient table for the audio mixer/limiter.
package amfl_pkg;

	// Port and datapath widths
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 9;
	localparam int LEVEL_W   = 4;
	localparam int VOL_W     = 7;
	localparam int CNT_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 9;
	localparam int DC_W      = 17;  // DC estimate stays within the input sample range
	localparam int LP_W      = 18;  // high-pass output and low-pass stages
	localparam int MIX_W     = 19;  // gained mix after the shift by 8
	localparam int SCL_W     = 18;  // volume-scaled mix
	localparam int ALPHA_W   = 15;
	localparam int MUL_A_W   = 20;
	localparam int MUL_B_W   = 17;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 40;
	localparam int STEP_W    = 3;
	localparam int LP_POLES  = 4;
	localparam int POLE_W    = 2;

	// Filter, volume and limiter constants
	localparam int DC_COEF       = 32700;
	localparam int DC_COEF_IN    = 32768 - DC_COEF;
	localparam int SETTLE_FRAMES = 2000;
	localparam int COUNT_MAX     = 2047;
	localparam int KNEE_START    = 24576;
	localparam int KNEE_SPAN     = 16384;
	localparam int FULL_SCALE    = 32767;
	localparam int UNITY_GAIN    = 256;
	localparam int MIX_LAST_STEP = 5;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNTH_GAIN_L  = 3'd0,
		REG_SYNTH_GAIN_R  = 3'd1,
		REG_DAC_GAIN_L    = 3'd2,
		REG_DAC_GAIN_R    = 3'd3,
		REG_SPEECH_GAIN_L = 3'd4,
		REG_SPEECH_GAIN_R = 3'd5,
		REG_FILTER_LEVEL  = 3'd6,
		REG_INIT_VOLUME   = 3'd7
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DC0,
		ST_DC1,
		ST_LP,
		ST_MIX,
		ST_VOL,
		ST_KNEE,
		ST_DONE
	} state_t;

	// Low-pass coefficient per filter level: (29000 * scale) >> 15
	function automatic logic [ALPHA_W-1:0] pole_coef(input logic [LEVEL_W-1:0] level);
		logic [ALPHA_W-1:0] a;
		case (level)
			4'd1:    a = 15'd1812;
			4'd2:    a = 15'd3625;
			4'd3:    a = 15'd5437;
			4'd4:    a = 15'd7250;
			4'd5:    a = 15'd9062;
			4'd6:    a = 15'd10875;
			4'd7:    a = 15'd12687;
			4'd8:    a = 15'd14500;
			4'd9:    a = 15'd16312;
			4'd10:   a = 15'd18125;
			4'd11:   a = 15'd19937;
			4'd12:   a = 15'd21750;
			4'd13:   a = 15'd24166;
			4'd14:   a = 15'd26583;
			4'd15:   a = 15'd29000;
			default: a = 15'd0;
		endcase
		return a;
	endfunction

endpackage

### design/amfl_mac.sv
// Shared signed multiply-accumulate unit used by every arithmetic step.
module amfl_mac (
	input  logic                               clk,
	input  logic                               clr,
	input  logic signed [amfl_pkg::MUL_A_W-1:0] a,
	input  logic signed [amfl_pkg::MUL_B_W-1:0] b,
	output logic signed [amfl_pkg::ACC_W-1:0]   sum
);

	logic signed [amfl_pkg::MUL_P_W-1:0] mul;
	logic signed [amfl_pkg::ACC_W-1:0]   acc_q;

	// product plus running sum; clr starts a new sum
	assign mul = a * b;
	assign sum = (clr ? '0 : acc_q) + amfl_pkg::ACC_W'(mul);

	always_ff @(posedge clk) begin
		acc_q <= sum;
	end

endmodule

### design/audio_mix_filter_limiter.sv
// Top level: speech filter, three-source mixer, settled volume and soft-knee limiter.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one stereo frame per item: synth
//   left/right, DAC sample, CVSD speech sample and the requested master volume.
//   Output channel (out_valid/out_ready) returns one limited stereo pair per item.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   gains, the filter level and the initial volume; write only while idle.
// Sequence:
//   One multiply-accumulate unit is stepped by the sequencer: 2 DC-blocker steps,
//   one step per low-pass pole (0 to 4, set by filter_level), 6 mix steps,
//   2 volume steps and 2 limiter steps. The result is registered in the output
//   register after the last limiter step; no new item is taken until the last
//   one has left the sequencer, so in_ready is low while an item is in work.
// Reset:
//   arst_n clears filter state, loads default gains (unity), filter level 1 and
//   volume 0. No clearing pass is needed.
// Stall:
//   The output register holds its item until taken; a finished item waits in
//   the sequencer, and no new item is accepted, until the output register frees.
module audio_mix_filter_limiter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input frames
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [amfl_pkg::SAMPLE_W-1:0]  synth_left,
	input  logic signed [amfl_pkg::SAMPLE_W-1:0]  synth_right,
	input  logic signed [amfl_pkg::SAMPLE_W-1:0]  dac_sample,
	input  logic signed [amfl_pkg::SAMPLE_W-1:0]  cvsd_sample,
	input  logic        [amfl_pkg::VOL_W-1:0]     master_volume,
	// output frames
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [amfl_pkg::SAMPLE_W-1:0]  out_left,
	output logic signed [amfl_pkg::SAMPLE_W-1:0]  out_right,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [amfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [amfl_pkg::CFG_DAT_W-1:0] cfg_data
);

	amfl_pkg::state_t state_q, state_d;
	logic [amfl_pkg::STEP_W-1:0] step_q;

	// configuration registers
	logic [amfl_pkg::GAIN_W-1:0]  g_synth_l_q, g_synth_r_q, g_dac_l_q, g_dac_r_q;
	logic [amfl_pkg::GAIN_W-1:0]  g_sp_l_q, g_sp_r_q;
	logic [amfl_pkg::LEVEL_W-1:0] level_q;

	// filter and volume state
	logic signed [amfl_pkg::DC_W-1:0] dc_q;
	logic signed [amfl_pkg::LP_W-1:0] stage_q [amfl_pkg::LP_POLES];
	logic [amfl_pkg::VOL_W-1:0]       stable_q, pending_q;
	logic [amfl_pkg::CNT_W-1:0]       cnt_q;

	// captured item and working registers
	logic signed [amfl_pkg::SAMPLE_W-1:0] sl_q, sr_q, dac_q, cv_q;
	logic [amfl_pkg::VOL_W-1:0]           req_q;
	logic signed [amfl_pkg::LP_W-1:0]     lp_q;
	logic signed [amfl_pkg::MIX_W-1:0]    mix_l_q, mix_r_q;
	logic signed [amfl_pkg::SCL_W-1:0]    scl_l_q, scl_r_q;
	logic signed [amfl_pkg::SAMPLE_W-1:0] lim_l_q, lim_r_q;
	logic signed [amfl_pkg::SAMPLE_W-1:0] out_l_q, out_r_q;
	logic                                 out_valid_q;

	// shared unit interface
	logic                                 mac_clr;
	logic signed [amfl_pkg::MUL_A_W-1:0]  mac_a;
	logic signed [amfl_pkg::MUL_B_W-1:0]  mac_b;
	logic signed [amfl_pkg::ACC_W-1:0]    mac_sum;

	logic                                 in_acc, cfg_acc, out_free;
	logic [amfl_pkg::POLE_W-1:0]          last_pole;
	logic [amfl_pkg::LEVEL_W-1:0]         level_m1;
	logic [amfl_pkg::ALPHA_W-1:0]         alpha;
	logic signed [amfl_pkg::LP_W-1:0]     stage_rd;
	logic signed [amfl_pkg::LP_W:0]       lp_step, lp_upd;
	logic signed [amfl_pkg::LP_W-1:0]     hp_in;

	// limiter signals
	logic signed [amfl_pkg::SCL_W-1:0]    vsel;
	logic                                 vneg, kpass, kbig;
	logic [amfl_pkg::SCL_W-1:0]           vmag;
	logic signed [amfl_pkg::SCL_W:0]      over;
	logic [amfl_pkg::MUL_B_W-1:0]         ksoft;
	logic [amfl_pkg::SAMPLE_W-1:0]        kmag;
	logic signed [amfl_pkg::SAMPLE_W-1:0] klim;

	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;

	// filter level decode: last pole index and coefficient
	assign level_m1  = level_q - amfl_pkg::LEVEL_W'(1);
	assign last_pole = level_m1[amfl_pkg::LEVEL_W-1:amfl_pkg::LEVEL_W-amfl_pkg::POLE_W];
	assign alpha     = amfl_pkg::pole_coef(level_q);
	assign stage_rd  = stage_q[step_q[amfl_pkg::POLE_W-1:0]];

	// high-pass input against the DC estimate held before this item
	assign hp_in = amfl_pkg::LP_W'(cvsd_sample) - amfl_pkg::LP_W'(dc_q);

	// low-pass update from the product
	assign lp_step = mac_sum[amfl_pkg::LP_W+15:15];
	assign lp_upd  = (amfl_pkg::LP_W+1)'(stage_rd) + lp_step;

	// soft knee on the selected channel
	assign vsel  = step_q[0] ? scl_r_q : scl_l_q;
	assign vneg  = vsel[amfl_pkg::SCL_W-1];
	assign vmag  = vneg ? amfl_pkg::SCL_W'(-vsel) : amfl_pkg::SCL_W'(vsel);
	assign over  = $signed({1'b0, vmag}) - (amfl_pkg::SCL_W+1)'(amfl_pkg::KNEE_START);
	assign kpass = vmag <= amfl_pkg::SCL_W'(amfl_pkg::KNEE_START);
	assign kbig  = over[amfl_pkg::SCL_W-1:0] >= amfl_pkg::SCL_W'(amfl_pkg::KNEE_SPAN);
	assign ksoft = amfl_pkg::MUL_B_W'(amfl_pkg::KNEE_START) + amfl_pkg::MUL_B_W'(over[14:0])
		- amfl_pkg::MUL_B_W'(mac_sum[27:15]);

	always_comb begin
		if (kbig || ksoft > amfl_pkg::MUL_B_W'(amfl_pkg::FULL_SCALE)) begin
			kmag = amfl_pkg::SAMPLE_W'(amfl_pkg::FULL_SCALE);
		end else begin
			kmag = ksoft[amfl_pkg::SAMPLE_W-1:0];
		end
		if (kpass) begin
			klim = vsel[amfl_pkg::SAMPLE_W-1:0];
		end else if (vneg) begin
			klim = -$signed(kmag);
		end else begin
			klim = $signed(kmag);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			amfl_pkg::ST_IDLE: begin
				if (in_acc) state_d = amfl_pkg::ST_DC0;
			end
			amfl_pkg::ST_DC0: state_d = amfl_pkg::ST_DC1;
			amfl_pkg::ST_DC1: begin
				state_d = (level_q == '0) ? amfl_pkg::ST_MIX : amfl_pkg::ST_LP;
			end
			amfl_pkg::ST_LP: begin
				if (step_q[amfl_pkg::POLE_W-1:0] == last_pole) state_d = amfl_pkg::ST_MIX;
			end
			amfl_pkg::ST_MIX: begin
				if (step_q == amfl_pkg::STEP_W'(amfl_pkg::MIX_LAST_STEP)) state_d = amfl_pkg::ST_VOL;
			end
			amfl_pkg::ST_VOL: begin
				if (step_q[0]) state_d = amfl_pkg::ST_KNEE;
			end
			amfl_pkg::ST_KNEE: begin
				if (step_q[0]) state_d = amfl_pkg::ST_DONE;
			end
			amfl_pkg::ST_DONE: begin
				if (out_free) state_d = amfl_pkg::ST_IDLE;
			end
			default: state_d = amfl_pkg::ST_IDLE;
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		in_ready = 1'b0;
		mac_clr  = 1'b1;
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			amfl_pkg::ST_IDLE: in_ready = 1'b1;
			amfl_pkg::ST_DC0: begin
				mac_a = amfl_pkg::MUL_A_W'(cv_q);
				mac_b = amfl_pkg::MUL_B_W'(amfl_pkg::DC_COEF_IN);
			end
			amfl_pkg::ST_DC1: begin
				mac_clr = 1'b0;
				mac_a   = amfl_pkg::MUL_A_W'(dc_q);
				mac_b   = amfl_pkg::MUL_B_W'(amfl_pkg::DC_COEF);
			end
			amfl_pkg::ST_LP: begin
				mac_a = amfl_pkg::MUL_A_W'(lp_q) - amfl_pkg::MUL_A_W'(stage_rd);
				mac_b = $signed(amfl_pkg::MUL_B_W'(alpha));
			end
			amfl_pkg::ST_MIX: begin
				mac_clr = (step_q == 3'd0) || (step_q == 3'd3);
				case (step_q)
					3'd0: begin
						mac_a = amfl_pkg::MUL_A_W'(sl_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_synth_l_q));
					end
					3'd1: begin
						mac_a = amfl_pkg::MUL_A_W'(dac_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_dac_l_q));
					end
					3'd2: begin
						mac_a = amfl_pkg::MUL_A_W'(lp_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_sp_l_q));
					end
					3'd3: begin
						mac_a = amfl_pkg::MUL_A_W'(sr_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_synth_r_q));
					end
					3'd4: begin
						mac_a = amfl_pkg::MUL_A_W'(dac_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_dac_r_q));
					end
					default: begin
						mac_a = amfl_pkg::MUL_A_W'(lp_q);
						mac_b = $signed(amfl_pkg::MUL_B_W'(g_sp_r_q));
					end
				endcase
			end
			amfl_pkg::ST_VOL: begin
				mac_a = step_q[0] ? amfl_pkg::MUL_A_W'(mix_r_q) : amfl_pkg::MUL_A_W'(mix_l_q);
				mac_b = $signed(amfl_pkg::MUL_B_W'(stable_q));
			end
			amfl_pkg::ST_KNEE: begin
				mac_a = $signed(amfl_pkg::MUL_A_W'(over[14:0]));
				mac_b = $signed(amfl_pkg::MUL_B_W'(over[14:0]));
			end
			default: ;
		endcase
	end

	amfl_mac u_mac (
		.clk (clk),
		.clr (mac_clr),
		.a   (mac_a),
		.b   (mac_b),
		.sum (mac_sum)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amfl_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + amfl_pkg::STEP_W'(1);
			end
		end
	end

	// configuration, filter state, volume settling and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_synth_l_q <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			g_synth_r_q <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			g_dac_l_q   <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			g_dac_r_q   <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			g_sp_l_q    <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			g_sp_r_q    <= amfl_pkg::GAIN_W'(amfl_pkg::UNITY_GAIN);
			level_q     <= amfl_pkg::LEVEL_W'(1);
			stable_q    <= '0;
			pending_q   <= '0;
			cnt_q       <= '0;
			dc_q        <= '0;
			for (int i = 0; i < amfl_pkg::LP_POLES; i++) stage_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes
			if (cfg_acc) begin
				case (amfl_pkg::reg_idx_t'(cfg_index))
					amfl_pkg::REG_SYNTH_GAIN_L:  g_synth_l_q <= cfg_data;
					amfl_pkg::REG_SYNTH_GAIN_R:  g_synth_r_q <= cfg_data;
					amfl_pkg::REG_DAC_GAIN_L:    g_dac_l_q   <= cfg_data;
					amfl_pkg::REG_DAC_GAIN_R:    g_dac_r_q   <= cfg_data;
					amfl_pkg::REG_SPEECH_GAIN_L: g_sp_l_q    <= cfg_data;
					amfl_pkg::REG_SPEECH_GAIN_R: g_sp_r_q    <= cfg_data;
					amfl_pkg::REG_FILTER_LEVEL:  level_q     <= cfg_data[amfl_pkg::LEVEL_W-1:0];
					amfl_pkg::REG_INIT_VOLUME: begin
						stable_q  <= cfg_data[amfl_pkg::VOL_W-1:0];
						pending_q <= cfg_data[amfl_pkg::VOL_W-1:0];
						cnt_q     <= '0;
					end
					default: ;
				endcase
			end

			// DC estimate update
			if (state_q == amfl_pkg::ST_DC1) begin
				dc_q <= mac_sum[amfl_pkg::DC_W+14:15];
			end

			// one low-pass pole per step
			if (state_q == amfl_pkg::ST_LP) begin
				stage_q[step_q[amfl_pkg::POLE_W-1:0]] <= lp_upd[amfl_pkg::LP_W-1:0];
			end

			// volume settles after the frame is finished
			if (state_q == amfl_pkg::ST_DONE && out_free) begin
				if (req_q != stable_q && req_q != pending_q) begin
					pending_q <= req_q;
					cnt_q     <= amfl_pkg::CNT_W'(1);
				end else begin
					if (req_q != stable_q && cnt_q > amfl_pkg::CNT_W'(amfl_pkg::SETTLE_FRAMES)) begin
						stable_q <= req_q;
					end
					if (cnt_q != amfl_pkg::CNT_W'(amfl_pkg::COUNT_MAX)) begin
						cnt_q <= cnt_q + amfl_pkg::CNT_W'(1);
					end
				end
			end

			// output item handshake
			if (state_q == amfl_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sl_q  <= synth_left;
			sr_q  <= synth_right;
			dac_q <= dac_sample;
			cv_q  <= cvsd_sample;
			req_q <= master_volume;
			lp_q  <= hp_in;
		end
		if (state_q == amfl_pkg::ST_LP) begin
			lp_q <= lp_upd[amfl_pkg::LP_W-1:0];
		end
		if (state_q == amfl_pkg::ST_MIX && step_q == 3'd2) begin
			mix_l_q <= mac_sum[amfl_pkg::MIX_W+7:8];
		end
		if (state_q == amfl_pkg::ST_MIX && step_q == amfl_pkg::STEP_W'(amfl_pkg::MIX_LAST_STEP)) begin
			mix_r_q <= mac_sum[amfl_pkg::MIX_W+7:8];
		end
		if (state_q == amfl_pkg::ST_VOL) begin
			if (step_q[0]) scl_r_q <= mac_sum[amfl_pkg::SCL_W+7:8];
			else           scl_l_q <= mac_sum[amfl_pkg::SCL_W+7:8];
		end
		if (state_q == amfl_pkg::ST_KNEE) begin
			if (step_q[0]) lim_r_q <= klim;
			else           lim_l_q <= klim;
		end
		if (state_q == amfl_pkg::ST_DONE && out_free) begin
			out_l_q <= lim_l_q;
			out_r_q <= lim_r_q;
		end
	end

endmodule
